// ===== sv/slid_pkg.sv =====
package slid_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned VALUE_W  = 32;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_DELETE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_REJECT_FULL,
    OP_REJECT_EMPTY
  } op_e;

  typedef enum logic {
    S_IDLE,
    S_HOLD
  } state_e;

  typedef struct packed {
    kind_e                      kind;
    logic signed [VALUE_W-1:0]  value;
  } in_req_t;

  typedef struct packed {
    status_e                    status;
    logic [COUNT_W-1:0]         count;
    logic signed [VALUE_W-1:0]  smallest;
  } out_res_t;

  typedef struct packed {
    logic load;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stat_t;

endpackage

// ===== sv/slid_ctrl.sv =====
module slid_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  slid_pkg::kind_e kind_i,
  input  logic          out_stall_i,
  input  slid_pkg::stat_t stat_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  output slid_pkg::cmd_t cmd_o
);
  import slid_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_HOLD;
      end
      S_HOLD: begin
        if (accept) begin
          state_d = S_HOLD;
        end else if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_o = (state_q == S_HOLD);
    // a new request may enter as the held result leaves
    in_stall_o  = (state_q == S_HOLD) && out_stall_i;
    cmd_o.load  = in_valid_i && !((state_q == S_HOLD) && out_stall_i);
    case (kind_i)
      KIND_INSERT: cmd_o.op = stat_i.full  ? OP_REJECT_FULL  : OP_INSERT;
      KIND_DELETE: cmd_o.op = stat_i.empty ? OP_REJECT_EMPTY : OP_DELETE;
      default:     cmd_o.op = OP_INSERT;
    endcase
  end

endmodule

// ===== sv/slid_dpath.sv =====
module slid_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slid_pkg::cmd_t    cmd_i,
  input  slid_pkg::in_req_t req_i,
  output slid_pkg::stat_t   stat_o,
  output slid_pkg::out_res_t res_o
);
  import slid_pkg::*;

  logic signed [VALUE_W-1:0] entries_q [CAPACITY];
  logic signed [VALUE_W-1:0] entries_d [CAPACITY];
  logic [CNT_W-1:0]          count_q, count_d;
  out_res_t                  res_q, res_d;
  logic [CAPACITY-1:0]       vld, lt, eq;
  logic                      found;

  // per-cell compare against the request value
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      vld[i] = (CNT_W'(i) < count_q);
      lt[i]  = vld[i] && (entries_q[i] < req_i.value);
      eq[i]  = vld[i] && (entries_q[i] == req_i.value);
    end
  end

  assign found = |eq;

  genvar g;
  for (g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VALUE_W-1:0] ins_v, del_v;
    if (g == 0) begin : g_first
      assign ins_v = req_i.value;
    end else begin : g_rest
      assign ins_v = lt[g-1] ? req_i.value : entries_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign del_v = entries_q[g];
    end else begin : g_inner
      assign del_v = entries_q[g+1];
    end
    always_comb begin
      case (cmd_i.op)
        OP_INSERT: entries_d[g] = lt[g] ? entries_q[g] : ins_v;
        // sorted order: the first equal cell sits right after the smaller ones
        OP_DELETE: entries_d[g] = (found && !lt[g]) ? del_v : entries_q[g];
        default:   entries_d[g] = entries_q[g];
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    case (cmd_i.op)
      OP_INSERT: begin
        count_d      = count_q + CNT_W'(1);
        res_d.status = STAT_OK;
      end
      OP_DELETE: begin
        if (found) begin
          count_d      = count_q - CNT_W'(1);
          res_d.status = STAT_OK;
        end else begin
          res_d.status = STAT_NOT_FOUND;
        end
      end
      OP_REJECT_FULL:  res_d.status = STAT_FULL;
      OP_REJECT_EMPTY: res_d.status = STAT_EMPTY;
      default:         res_d.status = STAT_OK;
    endcase
    res_d.count    = COUNT_W'(count_d);
    res_d.smallest = (count_d != '0) ? entries_d[0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.load) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      entries_q <= entries_d;
      res_q     <= res_d;
    end
  end

  assign stat_o.full  = (count_q == CNT_W'(CAPACITY));
  assign stat_o.empty = (count_q == '0);
  assign res_o        = res_q;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_no_insert_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && cmd_i.op == OP_INSERT) |-> !stat_o.full)
    else $error("insert issued into a full table");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && cmd_i.op == OP_INSERT) |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the count");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && (cmd_i.op == OP_REJECT_FULL || cmd_i.op == OP_REJECT_EMPTY))
    |=> $stable(count_q) && res_q.status != STAT_OK)
    else $error("refused request changed the table");
`endif

endmodule

// ===== sv/sorted_list_insert_delete_top.sv =====
// a result is registered and valid in the cycle after its request is accepted
// throughput: one request per cycle while results are taken; a single combinational
// row of compare-and-shift cells updates the whole table for each accepted request
// a held result that is stalled blocks new requests until it is taken
// reset clears the stored count and the result valid; table cells are not cleared
module sorted_list_insert_delete_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  slid_pkg::in_req_t   in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output slid_pkg::out_res_t  out_res_o
);
  import slid_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  slid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (in_req_i.kind),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  slid_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (in_req_i),
    .stat_o (stat),
    .res_o  (out_res_o)
  );

endmodule
